// ===== design/tpem_pkg.sv =====
// ----------------------------------------------------------------------------
// tpem_pkg: shared types and constants
// Field widths, fixed-point constants, register indexes and the packed
// structures that travel between the blocks of the elevon mixer.
// ----------------------------------------------------------------------------
package tpem_pkg;

  // Fixed-point format of errors, rates, terms and integrals.
  localparam int FRAC_BITS = 8;
  // The rate gain is always Q0.8.
  localparam int GAIN_BITS = 8;

  localparam int ERR_W   = 18;
  localparam int RATE_W  = 20;
  localparam int TERM_W  = 16;
  localparam int INT_W   = 15;
  localparam int SERVO_W = 7;
  // Working width of the signed datapath; holds every intermediate sum.
  localparam int CALC_W  = 26;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // Heading wrap limits in the working format.
  localparam logic signed [CALC_W-1:0] HEAD_BOUND = CALC_W'(180 * (1 << FRAC_BITS));
  localparam logic signed [CALC_W-1:0] HEAD_SHIFT = CALC_W'(270 * (1 << FRAC_BITS));

  // Servo travel limits and the smoothing filter's start value, whole degrees.
  localparam int SERVO_LOW  = 40;
  localparam int SERVO_HIGH = 120;
  localparam logic [SERVO_W-1:0] SERVO_RESET = SERVO_W'(80);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SERVO_BASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PID_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_XY_INT_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Z_INT_STEP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND   = 3'd6;

  typedef struct packed {
    logic [6:0]  servo_base;
    logic [14:0] pid_limit;
    logic [7:0]  rate_gain;
    logic [7:0]  xy_int_step;
    logic [7:0]  z_int_step;
    logic [12:0] int_limit;
    logic [10:0] dead_band;
  } cfg_t;

  // Last field in the lowest bits.
  typedef struct packed {
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_x;
    logic signed [ERR_W-1:0]  error_z;
    logic signed [ERR_W-1:0]  error_y;
    logic signed [ERR_W-1:0]  error_x;
  } in_item_t;

  typedef struct packed {
    logic signed [TERM_W-1:0] term_z;
    logic signed [TERM_W-1:0] term_y;
    logic signed [TERM_W-1:0] term_x;
  } terms_t;

endpackage

// ===== design/tpem_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tpem_cfg_regs: configuration register file
// Seven write-only tuning registers, loaded by index from the write port.
// ----------------------------------------------------------------------------
module tpem_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tpem_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tpem_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output tpem_pkg::cfg_t                   cfg
);
  import tpem_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.servo_base  <= 7'd80;
      cfg_r.pid_limit   <= 15'd7680;
      cfg_r.rate_gain   <= 8'd26;
      cfg_r.xy_int_step <= 8'd15;
      cfg_r.z_int_step  <= 8'd10;
      cfg_r.int_limit   <= 13'd3840;
      cfg_r.dead_band   <= 11'd384;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SERVO_BASE:  cfg_r.servo_base  <= cfg_wdata[6:0];
        REG_PID_LIMIT:   cfg_r.pid_limit   <= cfg_wdata[14:0];
        REG_RATE_GAIN:   cfg_r.rate_gain   <= cfg_wdata[7:0];
        REG_XY_INT_STEP: cfg_r.xy_int_step <= cfg_wdata[7:0];
        REG_Z_INT_STEP:  cfg_r.z_int_step  <= cfg_wdata[7:0];
        REG_INT_LIMIT:   cfg_r.int_limit   <= cfg_wdata[12:0];
        REG_DEAD_BAND:   cfg_r.dead_band   <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/tpem_axis_terms.sv =====
// ----------------------------------------------------------------------------
// tpem_axis_terms: integrators and clamped axis terms
// Holds the three integrals and the last errors, and forms the x, y and z
// control terms for the sample in the input register.
// ----------------------------------------------------------------------------
module tpem_axis_terms (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                upd_en,
  input  tpem_pkg::cfg_t      cfg,
  input  tpem_pkg::in_item_t  item,
  output tpem_pkg::terms_t    terms
);
  import tpem_pkg::*;

  logic signed [INT_W-1:0] integral_x_r, integral_y_r, integral_z_r;
  logic signed [INT_W-1:0] integral_x_nxt, integral_y_nxt, integral_z_nxt;
  logic signed [ERR_W-1:0] prior_x_r, prior_y_r, prior_z_r;

  logic signed [CALC_W-1:0] ex, ey, ez_raw, ez, px, py, pz;
  logic signed [CALC_W-1:0] db_s, lim_s, xy_step_s, z_step_s, plim_s;
  logic signed [CALC_W-1:0] ix_w, iy_w, iz_w, iz_base;
  logic signed [CALC_W-1:0] rt_x, rt_y, tx_raw, ty_raw;
  logic signed [RATE_W+GAIN_BITS:0] prod_x, prod_y;
  logic                     head_wrap;

  function automatic logic sign_flip(logic signed [CALC_W-1:0] prev,
                                     logic signed [CALC_W-1:0] cur);
    return (prev > 0 && cur < 0) || (prev < 0 && cur > 0);
  endfunction

  function automatic logic signed [TERM_W-1:0] clamp_term(
      logic signed [CALC_W-1:0] v, logic signed [CALC_W-1:0] lim);
    logic signed [CALC_W-1:0] r;
    r = v;
    if (v < -lim) r = -lim;
    else if (v > lim) r = lim;
    return TERM_W'(r);
  endfunction

  assign ex     = CALC_W'(item.error_x);
  assign ey     = CALC_W'(item.error_y);
  assign ez_raw = CALC_W'(item.error_z);
  assign px     = CALC_W'(prior_x_r);
  assign py     = CALC_W'(prior_y_r);
  assign pz     = CALC_W'(prior_z_r);

  assign db_s      = CALC_W'(cfg.dead_band);
  assign lim_s     = CALC_W'(cfg.int_limit);
  assign xy_step_s = CALC_W'(cfg.xy_int_step);
  assign z_step_s  = CALC_W'(cfg.z_int_step);
  assign plim_s    = CALC_W'(cfg.pid_limit);

  // A heading error past half a turn is moved back by three quarters of one.
  always_comb begin
    head_wrap = 1'b1;
    if (ez_raw < -HEAD_BOUND) ez = ez_raw + HEAD_SHIFT;
    else if (ez_raw > HEAD_BOUND) ez = ez_raw - HEAD_SHIFT;
    else begin
      ez        = ez_raw;
      head_wrap = 1'b0;
    end
  end

  // Rate feedback, floored by the arithmetic shift.
  assign prod_x = $signed({1'b0, cfg.rate_gain}) * item.rate_x;
  assign prod_y = $signed({1'b0, cfg.rate_gain}) * item.rate_y;
  assign rt_x   = CALC_W'(prod_x >>> GAIN_BITS);
  assign rt_y   = CALC_W'(prod_y >>> GAIN_BITS);

  // The x integral runs opposite to its error.
  always_comb begin
    ix_w = CALC_W'(integral_x_r);
    if (ex > db_s) begin
      ix_w = ix_w - xy_step_s;
      if (ix_w < -lim_s) ix_w = -lim_s;
    end else if (ex < -db_s) begin
      ix_w = ix_w + xy_step_s;
      if (ix_w > lim_s) ix_w = lim_s;
    end else begin
      ix_w = '0;
    end
    if (sign_flip(px, ex)) ix_w = '0;
  end

  always_comb begin
    iy_w = CALC_W'(integral_y_r);
    if (ey > db_s) begin
      iy_w = iy_w + xy_step_s;
      if (iy_w > lim_s) iy_w = lim_s;
    end else if (ey < -db_s) begin
      iy_w = iy_w - xy_step_s;
      if (iy_w < -lim_s) iy_w = -lim_s;
    end else begin
      iy_w = '0;
    end
    if (sign_flip(py, ey)) iy_w = '0;
  end

  // The z integral jumps to twice the limit once it passes it.
  assign iz_base = head_wrap ? '0 : CALC_W'(integral_z_r);

  always_comb begin
    iz_w = iz_base;
    if (ez > db_s) begin
      iz_w = iz_w + z_step_s;
      if (iz_w > lim_s) iz_w = lim_s <<< 1;
    end else if (ez < -db_s) begin
      iz_w = iz_w - z_step_s;
      if (iz_w < -lim_s) iz_w = -(lim_s <<< 1);
    end else begin
      iz_w = '0;
    end
    if (sign_flip(pz, ez)) iz_w = '0;
  end

  assign integral_x_nxt = INT_W'(ix_w);
  assign integral_y_nxt = INT_W'(iy_w);
  assign integral_z_nxt = INT_W'(iz_w);

  assign tx_raw = -ex - rt_x + ix_w;
  assign ty_raw = ey + rt_y + iy_w + iz_w;

  assign terms.term_x = clamp_term(tx_raw, plim_s);
  assign terms.term_y = clamp_term(ty_raw, plim_s);
  assign terms.term_z = clamp_term(ez, plim_s);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_x_r <= '0;
      integral_y_r <= '0;
      integral_z_r <= '0;
      prior_x_r    <= '0;
      prior_y_r    <= '0;
      prior_z_r    <= '0;
    end else if (upd_en) begin
      integral_x_r <= integral_x_nxt;
      integral_y_r <= integral_y_nxt;
      integral_z_r <= integral_z_nxt;
      prior_x_r    <= item.error_x;
      prior_y_r    <= item.error_y;
      prior_z_r    <= ERR_W'(ez);
    end
  end

endmodule

// ===== design/tpem_servo_mix.sv =====
// ----------------------------------------------------------------------------
// tpem_servo_mix: elevon mixer and servo smoothing
// Mixes the axis terms onto two servos, limits their travel and averages
// each with its previous command.
// ----------------------------------------------------------------------------
module tpem_servo_mix (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            upd_en,
  input  logic [6:0]                      servo_base,
  input  tpem_pkg::terms_t                terms,
  output logic [tpem_pkg::SERVO_W-1:0]    servo_one,
  output logic [tpem_pkg::SERVO_W-1:0]    servo_two
);
  import tpem_pkg::*;

  logic [SERVO_W-1:0]       smooth_one_r, smooth_two_r;
  logic signed [CALC_W-1:0] base_w, tx, ty, tz, s1, s2, q1, q2;
  logic [SERVO_W-1:0]       c1, c2;
  logic [SERVO_W:0]         sum1, sum2;

  function automatic logic [SERVO_W-1:0] clamp_servo(logic signed [CALC_W-1:0] v);
    logic [SERVO_W-1:0] r;
    if (v < SERVO_LOW) r = SERVO_W'(SERVO_LOW);
    else if (v > SERVO_HIGH) r = SERVO_W'(SERVO_HIGH);
    else r = SERVO_W'(v);
    return r;
  endfunction

  assign base_w = CALC_W'(servo_base) <<< FRAC_BITS;
  assign tx     = CALC_W'(terms.term_x);
  assign ty     = CALC_W'(terms.term_y);
  assign tz     = CALC_W'(terms.term_z);

  // Sums carry two extra fraction bits so that a quarter of z stays exact.
  always_comb begin
    s1 = (base_w + tx + ty) <<< 2;
    s2 = (base_w - tx + ty) <<< 2;
    if (tz > 0) begin
      s1 = s1 + (tz <<< 2);
      s2 = s2 - tz;
    end else begin
      s1 = s1 - tz;
      s2 = s2 + (tz <<< 2);
    end
  end

  assign q1 = s1 >>> (FRAC_BITS + 2);
  assign q2 = s2 >>> (FRAC_BITS + 2);
  assign c1 = clamp_servo(q1);
  assign c2 = clamp_servo(q2);

  assign sum1      = {1'b0, smooth_one_r} + {1'b0, c1};
  assign sum2      = {1'b0, smooth_two_r} + {1'b0, c2};
  assign servo_one = sum1[SERVO_W:1];
  assign servo_two = sum2[SERVO_W:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_one_r <= SERVO_RESET;
      smooth_two_r <= SERVO_RESET;
    end else if (upd_en) begin
      smooth_one_r <= servo_one;
      smooth_two_r <= servo_two;
    end
  end

endmodule

// ===== design/three_axis_pi_elevon_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// three_axis_pi_elevon_mixer_unit: three-axis PI controller with elevon mix
// Turns attitude errors and rates into clamped axis terms and two smoothed
// servo angles, one sample per transaction.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries
//  in_*      sink       one sample: x, y, z errors and x, y rates
//  out_*     source     two servo angles and the three clamped axis terms
//  cfg_*     sink       write-only tuning registers, one per index 0 to 6
//
// A sample is taken into the input register, and the whole update (rate
// products, integrators, clamps, mixer, smoothing) is combinational from
// there into the output register, so the block sustains one transaction
// per clock while out_tready stays high. An accepted sample reaches
// out_tvalid through the input register, then the output register once free.
// The input register frees itself whenever the output register is empty or
// being drained, so an output stall holds at most two samples inside, one in
// each register, and then drops in_tready.
// rst_n is synchronous: it restores the register defaults, clears the
// integrals and last errors, and sets both smoothed servos to 80 degrees.
//
module three_axis_pi_elevon_mixer_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // error_x[17:0], error_y[35:18], error_z[53:36], rate_x[73:54],
  // rate_y[93:74], zero padding above
  input  logic [tpem_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // servo_one_angle[6:0], servo_two_angle[13:7], term_x[29:14],
  // term_y[45:30], term_z[61:46], zero padding above
  output logic [tpem_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                             cfg_we,
  input  logic [tpem_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tpem_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tpem_pkg::*;

  cfg_t               cfg;
  in_item_t           item_r;
  logic               item_valid_r;
  logic               out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic               advance;
  terms_t             terms;
  logic [SERVO_W-1:0] servo_one, servo_two;

  // The sample in the input register moves on when the output slot is free
  // or being emptied in this same cycle; that is also when state updates.
  assign advance   = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || advance;

  tpem_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tpem_axis_terms u_axis (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_en (advance),
    .cfg    (cfg),
    .item   (item_r),
    .terms  (terms)
  );

  tpem_servo_mix u_mix (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd_en     (advance),
    .servo_base (cfg.servo_base),
    .terms      (terms),
    .servo_one  (servo_one),
    .servo_two  (servo_two)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_tdata[$bits(in_item_t)-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= OUT_DATA_W'({terms.term_z, terms.term_y, terms.term_x,
                                 servo_two, servo_one});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  // A sample that leaves the input register shows up at the output next.
  a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_tvalid)
    else $error("advanced sample did not reach the output register");

  // With both registers full and the output stalled, no new sample may enter.
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input accepted while pipeline is full and stalled");

  // Smoothed servo commands never leave the travel limits.
  a_servo_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_data_r[6:0] >= SERVO_W'(SERVO_LOW)) &&
                   (out_data_r[6:0] <= SERVO_W'(SERVO_HIGH)) &&
                   (out_data_r[13:7] >= SERVO_W'(SERVO_LOW)) &&
                   (out_data_r[13:7] <= SERVO_W'(SERVO_HIGH)))
    else $error("servo angle outside travel limits");

  // An accepted sample is held in the input register on the next cycle.
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> item_valid_r)
    else $error("accepted sample lost from the input register");
`endif

endmodule
